[hdl/lois_pkg.sv]
// Shared types, codes and defaults for the line offset index search unit.
// No dependencies; every other file in this block imports it.

package lois_pkg;

   // Default sizes of the offset table
   localparam int unsigned DEF_MAX_LINES   = 1024;
   localparam int unsigned DEF_OFFSET_BITS = 24;

   // Fixed field widths of the item channels
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned LEN_W    = 24;
   localparam int unsigned POS_W    = 24;
   localparam int unsigned LINE_W   = 11;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned VALUE_W  = 24;

   // Each line ends in one newline character
   localparam int unsigned NEWLINE_CHARS = 1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LINE_OF_INDEX = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INDEX_OF_LINE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [LEN_W-1:0]  line_length;
      logic [POS_W-1:0]  char_index;
      logic [LINE_W-1:0] line_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } rsp_type;

   // Table port controls from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tbl_ctl_type;

endpackage

[hdl/lois_table.sv]
// Line end offset table: one write port, one read port with registered data.
// Depends on lois_pkg for the control struct and defaults.

module lois_table import lois_pkg::*; #(
   parameter int unsigned DEPTH = DEF_MAX_LINES,
   parameter int unsigned WIDTH = DEF_OFFSET_BITS,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  tbl_ctl_type       ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the new end offset, register the read word
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lois_ctrl.sv]
// Command sequencer: append, start lookup and a binary search that uses one
// compare per cycle against the table read port. Depends on lois_pkg.

module lois_ctrl import lois_pkg::*; #(
   parameter int unsigned MAX_LINES   = DEF_MAX_LINES,
   parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS,
   localparam int unsigned AW         = $clog2(MAX_LINES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req,
   input  logic                   out_free,
   output tbl_ctl_type            tbl_ctl,
   output logic [AW-1:0]          wr_addr,
   output logic [OFFSET_BITS-1:0] wr_data,
   output logic [AW-1:0]          rd_addr,
   input  logic [OFFSET_BITS-1:0] rd_data,
   output logic                   res_valid,
   output rsp_type                res,
   output logic                   busy
);

   localparam int unsigned CW = $clog2(MAX_LINES + 1);
   localparam int unsigned LW = (CW > LINE_W) ? CW : LINE_W;
   localparam int unsigned EW = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
   localparam int unsigned PW = (OFFSET_BITS > POS_W) ? OFFSET_BITS : POS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [OFFSET_BITS-1:0] total_ff, total_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          lo_ff, lo_in;
   logic [CW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          mid_ff, mid_in;

   logic [EW-1:0]          new_end;
   logic                   append_ok;
   logic [CW-1:0]          count_inc;
   logic [PW-1:0]          pos_x;
   logic                   pos_out;
   logic [LW-1:0]          line_x;
   logic                   line_out;
   logic                   cmp_lt;
   logic [CW-1:0]          lo_n, hi_n;
   logic [CW:0]            mid_sum;
   logic [AW-1:0]          mid_n;

   // Append check: table room and offset width
   assign new_end   = EW'(total_ff) + EW'(req.line_length) + EW'(NEWLINE_CHARS);
   assign append_ok = (count_ff != CW'(MAX_LINES)) && (new_end <= EW'({OFFSET_BITS{1'b1}}));
   assign count_inc = count_ff + CW'(1);

   // Range checks of the two queries
   assign pos_x    = PW'(req.char_index);
   assign pos_out  = pos_x >= PW'(total_ff);
   assign line_x   = LW'(req.line_number);
   assign line_out = (line_x == '0) || (line_x > LW'(count_ff));

   // Shared compare: narrow the search window around the word just read
   assign cmp_lt  = pos_ff < PW'(rd_data);
   assign lo_n    = cmp_lt ? lo_ff : (CW'(mid_ff) + CW'(1));
   assign hi_n    = cmp_lt ? CW'(mid_ff) : hi_ff;
   assign mid_sum = (CW + 1)'(lo_n) + (CW + 1)'(hi_n);
   assign mid_n   = mid_sum[AW:1];

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      pos_in         = pos_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      tbl_ctl.wr_en  = 1'b0;
      res_valid      = 1'b0;
      res.status     = ST_OK;
      res.value      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.command)
                  CMD_APPEND: begin
                     res_valid = 1'b1;
                     if (append_ok) begin
                        tbl_ctl.wr_en = 1'b1;
                        count_in      = count_inc;
                        total_in      = new_end[OFFSET_BITS-1:0];
                        res.value     = VALUE_W'(count_inc);
                     end else begin
                        res.status = ST_FULL;
                        res.value  = VALUE_W'(count_ff);
                     end
                  end
                  CMD_LINE_OF_INDEX: begin
                     if (pos_out) begin
                        res_valid  = 1'b1;
                        res.status = ST_RANGE;
                     end else begin
                        pos_in   = pos_x;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = AW'(count_ff >> 1);
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_INDEX_OF_LINE: begin
                     if (line_out) begin
                        res_valid  = 1'b1;
                        res.status = ST_RANGE;
                     end else if (line_x == LW'(1)) begin
                        res_valid = 1'b1;
                     end else begin
                        mid_in   = AW'(line_x - LW'(2));
                        state_in = S_LOOKUP;
                     end
                  end
                  default: begin
                     res_valid  = 1'b1;
                     res.status = ST_RANGE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_n == hi_n) begin
               // Window closed: hold until the output register is free
               if (out_free) begin
                  res_valid = 1'b1;
                  state_in  = S_IDLE;
                  if (lo_n == count_ff) begin
                     res.status = ST_RANGE;
                  end else begin
                     res.value = VALUE_W'(lo_n) + VALUE_W'(1);
                  end
               end
            end else begin
               lo_in  = lo_n;
               hi_in  = hi_n;
               mid_in = mid_n;
            end
         end
         S_LOOKUP: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.value = VALUE_W'(rd_data);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Read at the next probe while a query is in flight
      tbl_ctl.rd_en = (state_in != S_IDLE);
   end

   // Table port: probe address, write at the line count
   assign rd_addr       = mid_in;
   assign wr_addr       = AW'(count_ff);
   assign wr_data       = new_end[OFFSET_BITS-1:0];
   assign busy          = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   // Search registers hold payload only
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
   end

endmodule

[hdl/line_offset_index_search_unit.sv]
// Top level of the line offset index search unit: sequencer, offset table
// and result register. Depends on lois_pkg, lois_ctrl and lois_table.

// Keeps the cumulative end offset of each appended line (length plus one
// newline) and answers two queries: the 1-based line that holds a character
// offset, and the start offset of a 1-based line. One item is worked on at a
// time and req_stall stays high meanwhile. An append, an unused command, a
// start offset query for line 1 and any query that is out of range give their
// result in the cycle after acceptance; any other start offset query reads
// the table in a lookup state first; a line-of-offset query runs a binary
// search making one table read and one offset compare per cycle on the
// single table read port, then waits for a free result register.
// The result sits in an output register, so a new item may be accepted in the
// cycle that the previous result is taken. The table needs no clearing after
// reset: only entries below the line count are ever read.

module line_offset_index_search_unit import lois_pkg::*; #(
   parameter int unsigned MAX_LINES   = DEF_MAX_LINES,
   parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(MAX_LINES);

   tbl_ctl_type            tbl_ctl;
   logic [AW-1:0]          wr_addr;
   logic [OFFSET_BITS-1:0] wr_data;
   logic [AW-1:0]          rd_addr;
   logic [OFFSET_BITS-1:0] rd_data;
   logic                   res_valid;
   rsp_type                res;
   logic                   busy;
   logic                   out_free;
   logic                   req_accept;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // Result register is free when empty or being taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy || !out_free;
   assign req_accept = req_valid && !req_stall;

   lois_ctrl #(
      .MAX_LINES   (MAX_LINES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .req       (req_data),
      .out_free  (out_free),
      .tbl_ctl   (tbl_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .busy      (busy)
   );

   lois_table #(
      .DEPTH (MAX_LINES),
      .WIDTH (OFFSET_BITS)
   ) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Load a new item into the result register, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/lois_chk.sv]
// Port checker for the line offset index search unit, bound to the top level.
// Depends on lois_pkg and line_offset_index_search_unit.

module lois_chk import lois_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item present after reset");

   // An accepted item either has its result waiting or keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !reset) |=> (rsp_valid || req_stall))
      else $error("block free with no result after accepting an item");

   // An out of range result carries a zero value
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_RANGE) |-> (rsp_data.value == '0))
      else $error("out of range item with non-zero value");

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item changed");

endmodule

bind line_offset_index_search_unit lois_chk u_lois_chk (.*);

[dv/lois_checker.sv]
// Result checker for the line offset index search unit: keeps its own copy
// of the line end table, predicts the answer to each item and compares.
// Depends on lois_pkg.

module lois_checker import lois_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output int unsigned fault_count,
   output int unsigned answers_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [VALUE_W:0] OFFSET_TOP = (VALUE_W + 1)'((1 << DEF_OFFSET_BITS) - 1);

   logic [VALUE_W-1:0] line_ends [DEF_MAX_LINES];
   int unsigned        lines_held;
   logic [VALUE_W-1:0] text_length;
   rsp_type            pending_answers [$];
   int unsigned        results_seen;
   int unsigned        faults;

   // Count a fault; report only the first few in full
   task automatic note_fault(input string what);
      faults++;
      if (faults <= 10) begin
         $display("%0t ns: result %0d: %s", $time, results_seen, what);
      end
   endtask

   // Work out the answer to one item and advance the table copy
   function automatic rsp_type answer_of(req_type it);
      rsp_type          ans;
      logic [VALUE_W:0] new_end;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      ans.status = ST_RANGE;
      ans.value  = '0;
      case (it.command)
         CMD_APPEND: begin
            new_end = (VALUE_W + 1)'(text_length) + (VALUE_W + 1)'(it.line_length)
                      + (VALUE_W + 1)'(NEWLINE_CHARS);
            if (lines_held >= DEF_MAX_LINES || new_end > OFFSET_TOP) begin
               ans.status = ST_FULL;
               ans.value  = VALUE_W'(lines_held);
            end else begin
               line_ends[lines_held] = new_end[VALUE_W-1:0];
               lines_held++;
               text_length = new_end[VALUE_W-1:0];
               ans.status  = ST_OK;
               ans.value   = VALUE_W'(lines_held);
            end
         end
         CMD_LINE_OF_INDEX: begin
            // first line whose end lies beyond the offset
            if (it.char_index < text_length) begin
               lo = 0;
               hi = lines_held;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (it.char_index < line_ends[mid]) hi = mid;
                  else lo = mid + 1;
               end
               if (lo < lines_held) begin
                  ans.status = ST_OK;
                  ans.value  = VALUE_W'(lo + 1);
               end
            end
         end
         CMD_INDEX_OF_LINE: begin
            // a line starts where the one before it ends
            if (it.line_number != 0 && it.line_number <= lines_held) begin
               ans.status = ST_OK;
               if (it.line_number > 1) ans.value = line_ends[it.line_number - 2];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         lines_held   = 0;
         text_length  = '0;
         results_seen = 0;
         faults       = 0;
         pending_answers.delete();
         fault_count <= 0;
         answers_due <= 0;
      end else begin
         // Compare the result taken at this edge with the oldest answer due
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               note_fault($sformatf("unexpected result, status %0d value %0d",
                                    rsp_data.status, rsp_data.value));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.value !== want.value) begin
                  note_fault($sformatf("status exp %0d got %0d, value exp %0d got %0d",
                                       want.status, rsp_data.status,
                                       want.value, rsp_data.value));
               end
            end
            results_seen++;
         end
         // Predict the answer to an item taken at this edge
         if (req_valid && !req_stall) begin
            fresh           = answer_of(req_data);
            pending_answers = {pending_answers, fresh};
         end
         answers_due <= pending_answers.size();
         fault_count <= faults;
      end
   end

endmodule

[dv/tb_top.sv]
// Testbench top for the line offset index search unit: builds the text line
// by line, queries it, stalls the result side and gives the verdict.
// Depends on lois_pkg, line_offset_index_search_unit and lois_checker.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lois_pkg::*;

   localparam int unsigned      OFFSET_TOP   = (1 << DEF_OFFSET_BITS) - 1;
   localparam int unsigned      LEN_TOP      = OFFSET_TOP - 1;
   localparam int unsigned      RANDOM_ITEMS = 250;
   localparam int unsigned      IDLE_LIMIT   = 3000;
   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned fault_count;
   int unsigned answers_due;
   int unsigned lines_made = 0;
   int unsigned text_used  = 0;
   int unsigned items_sent = 0;
   bit          steady     = 1'b0;

   line_offset_index_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lois_checker answer_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fault_count (fault_count),
      .answers_due (answers_due)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Fill the fields that the command ignores with noise
   function automatic req_type blank_item(logic [CMD_W-1:0] cmd);
      req_type it;
      it.command     = cmd;
      it.line_length = LEN_W'($urandom_range(0, LEN_TOP));
      it.char_index  = POS_W'($urandom);
      it.line_number = LINE_W'($urandom);
      return it;
   endfunction

   // Append a line; track the text size when the unit will take it
   function automatic req_type append_item(int unsigned len);
      req_type it;
      it = blank_item(CMD_APPEND);
      it.line_length = LEN_W'(len);
      if (lines_made < DEF_MAX_LINES && text_used + len + NEWLINE_CHARS <= OFFSET_TOP) begin
         lines_made++;
         text_used += len + NEWLINE_CHARS;
      end
      return it;
   endfunction

   function automatic req_type offset_query(int unsigned pos);
      req_type it;
      it = blank_item(CMD_LINE_OF_INDEX);
      it.char_index = POS_W'(pos);
      return it;
   endfunction

   function automatic req_type line_query(int unsigned line);
      req_type it;
      it = blank_item(CMD_INDEX_OF_LINE);
      it.line_number = LINE_W'(line);
      return it;
   endfunction

   // Mostly short lines and queries inside the text, some edges and noise
   function automatic req_type random_item(int unsigned append_pct);
      int unsigned pick;
      int unsigned len;
      int unsigned pos;
      int unsigned line;
      pick = $urandom_range(0, 99);
      if (pick < append_pct) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) len = $urandom_range(0, 3);
         else if (pick < 85) len = $urandom_range(0, 200);
         else if (pick < 97 || text_used == 0) len = $urandom_range(0, 4095);
         else len = $urandom_range(OFFSET_TOP - text_used, LEN_TOP);
         return append_item(len);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) pos = (text_used == 0) ? 0 : $urandom_range(0, text_used - 1);
         else if (pick < 80) pos = text_used - $urandom_range(0, 1);
         else if (pick < 90) pos = $urandom;
         else pos = $urandom_range(0, text_used + 16);
         return offset_query(pos);
      end
      if (pick < 92) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) line = $urandom_range(0, lines_made + 1);
         else if (pick < 90) line = pick[0] ? lines_made : 1;
         else line = $urandom;
         return line_query(line);
      end
      return blank_item(CMD_UNUSED);
   endfunction

   function automatic int unsigned next_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one item after a random gap and hold it until taken
   task automatic send_item(req_type it);
      int unsigned gap;
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering until every answer due has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
   endtask

   // Result side: free runs, stall bursts, random stalls, one long hold-off
   initial begin : result_side
      bit          held_once;
      int unsigned pick;
      held_once = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         if (!held_once && items_sent >= 400) begin
            held_once = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (pick < 20) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(10, 80)) @(posedge clock);
         end else if (pick < 27) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(5, 30)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 40);
            @(posedge clock);
         end
      end
   end

   // Give up when nothing moves on either channel for too long
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("** line_offset_index_search_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int unsigned n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Queries on an empty text, then a one-character line
      send_item(offset_query(0));
      send_item(line_query(0));
      send_item(line_query(1));
      send_item(blank_item(CMD_UNUSED));
      send_item(append_item(0));
      send_item(offset_query(0));
      send_item(offset_query(1));
      send_item(line_query(1));
      send_item(line_query(2));
      // longest line ends one past the top offset: rejected
      send_item(append_item(LEN_TOP));
      send_item(append_item(5));
      send_item(offset_query(1));
      send_item(offset_query(6));
      send_item(offset_query(7));
      send_item(offset_query(OFFSET_TOP));
      send_item(line_query(2));
      send_item(line_query(3));
      send_item(line_query(2047));
      send_item(blank_item(CMD_UNUSED));
      wait_drained();

      // Random mix, with stretches of back-to-back items
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = ((n / 80) % 4 == 2);
         if (n == 150) wait_drained();
         send_item(random_item(60));
      end
      steady = 1'b0;

      // Fill the table to one line short of full
      while (lines_made < DEF_MAX_LINES - 1) send_item(random_item(100));

      // Last line ends just under the top offset; then reject on count alone
      send_item(append_item(OFFSET_TOP - 2 - text_used));
      send_item(append_item(0));
      send_item(append_item(LEN_TOP));
      send_item(line_query(DEF_MAX_LINES));
      send_item(line_query(DEF_MAX_LINES + 1));
      send_item(offset_query(text_used - 1));
      send_item(offset_query(text_used));
      for (n = 0; n < 60; n++) send_item(random_item(10));

      wait_drained();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && answers_due == 0) begin
         $display("** line_offset_index_search_unit: PASSED **");
      end else begin
         $display("** line_offset_index_search_unit: FAILED **");
      end
      $finish;
   end

endmodule
